[hdl/brc_pkg.sv]
`default_nettype none
package brc_pkg;

    localparam int unsigned DivBits = 32;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TEMP_DIV = 2'd1;
    localparam logic [1:0] STATUS_PRES_DIV = 2'd2;

    localparam logic [2:0] REG_CAL_FIRST  = 3'd0;
    localparam logic [2:0] REG_CAL_SECOND = 3'd1;
    localparam logic [2:0] REG_CAL_B      = 3'd2;
    localparam logic [2:0] REG_CAL_M      = 3'd3;
    localparam logic [2:0] REG_OSS        = 3'd4;

    typedef struct packed {
        logic [31:0] ac1;
        logic [31:0] ac2;
        logic [31:0] ac3;
        logic [31:0] ac4;
        logic [31:0] ac5;
        logic [31:0] ac6;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] mc;
        logic [31:0] md;
        logic [1:0]  oss;
    } cal_t;

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
        asr32 = 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

endpackage
`default_nettype wire

[hdl/brc_div_stage.sv]
`default_nettype none
module brc_div_stage #(
    parameter int unsigned W = 32,
    parameter int unsigned S = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         v,
    input  wire logic [W-1:0] n_in,
    input  wire logic [W-1:0] d,
    input  wire logic [W-1:0] q_in,
    input  wire logic [W-1:0] r_in,
    output logic              v_reg,
    output logic [W-1:0]      n_reg,
    output logic [W-1:0]      d_reg,
    output logic [W-1:0]      q_reg,
    output logic [W-1:0]      r_reg
);
    // Restoring division, S quotient bits per stage, MSB first.
    logic [W-1:0] n_next;
    logic [W-1:0] q_next;
    logic [W-1:0] r_next;
    logic [W:0]   t;

    always_comb
    begin
        n_next = n_in;
        q_next = q_in;
        r_next = r_in;
        for (int i = 0; i < S; i++)
        begin
            t = {r_next, n_next[W-1]};
            n_next = {n_next[W-2:0], 1'b0};
            if (t >= {1'b0, d})
            begin
                t = t - {1'b0, d};
                q_next = {q_next[W-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_next[W-2:0], 1'b0};
            end
            r_next = t[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        d_reg <= d;
        q_reg <= q_next;
        r_reg <= r_next;
    end
endmodule
`default_nettype wire

[hdl/barometer_reading_compensation_core.sv]
`default_nettype none
// Channel   | Ports                                           | Transfer
// config    | cfg_we, cfg_index, cfg_data                     | cfg_we high
// input     | raw_temperature, raw_pressure                   | start & !busy
// result    | temperature_tenths, pressure_pa, status         | done high
// One item may start every cycle; busy is always low.
// Each result passes through two pipelined restoring dividers of four bits
// per stage (8 stages each) and through the multiply stages.
// Reset clears the calibration registers and all valid bits.
// The receiver cannot stall; each result is shown for one cycle with done.
module barometer_reading_compensation_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [15:0]  raw_temperature,
    input  wire logic [18:0]  raw_pressure,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [47:0]  cfg_data,
    output logic              done,
    output logic signed [15:0] temperature_tenths,
    output logic signed [31:0] pressure_pa,
    output logic [1:0]        status
);
    import brc_pkg::*;

    localparam int unsigned DS = 4;
    localparam int unsigned NS = DivBits / DS;
    localparam int unsigned LAT = 11 + 2 * NS;

    logic [47:0] c1_reg, c2_reg;
    logic [31:0] cb_reg, cm_reg;
    logic [1:0]  oss_reg;
    cal_t cal;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0; c2_reg <= '0; cb_reg <= '0; cm_reg <= '0; oss_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CAL_FIRST:  c1_reg <= cfg_data;
                REG_CAL_SECOND: c2_reg <= cfg_data;
                REG_CAL_B:      cb_reg <= cfg_data[31:0];
                REG_CAL_M:      cm_reg <= cfg_data[31:0];
                REG_OSS:        oss_reg <= cfg_data[1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        cal.ac1 = sx16(c1_reg[47:32]);
        cal.ac2 = sx16(c1_reg[31:16]);
        cal.ac3 = sx16(c1_reg[15:0]);
        cal.ac4 = {16'd0, c2_reg[47:32]};
        cal.ac5 = {16'd0, c2_reg[31:16]};
        cal.ac6 = {16'd0, c2_reg[15:0]};
        cal.b1  = sx16(cb_reg[31:16]);
        cal.b2  = sx16(cb_reg[15:0]);
        cal.mc  = sx16(cm_reg[31:16]);
        cal.md  = sx16(cm_reg[15:0]);
        cal.oss = oss_reg;
    end

    // s1: x1 product
    logic        v1_reg;
    logic [31:0] p1_reg;
    logic [18:0] up1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else        v1_reg <= start;
    end
    always_ff @(posedge clk)
    begin
        p1_reg  <= ({16'd0, raw_temperature} - cal.ac6) * cal.ac5;
        up1_reg <= raw_pressure;
    end

    // s2: divisor, sign handling for the temperature division
    logic [31:0] x1_2, den2, num2;
    logic        v2_reg, z2_reg, neg2_reg;
    logic [31:0] x12_reg, an2_reg, ad2_reg;
    logic [18:0] up2_reg;
    always_comb
    begin
        x1_2 = asr32(p1_reg, 5'd15);
        den2 = x1_2 + cal.md;
        num2 = cal.mc << 11;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v2_reg <= 1'b0;
        else        v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        x12_reg  <= x1_2;
        z2_reg   <= (den2 == 32'd0);
        neg2_reg <= num2[31] ^ den2[31];
        an2_reg  <= num2[31] ? 32'(-num2) : num2;
        ad2_reg  <= den2[31] ? 32'(-den2) : den2;
        up2_reg  <= up1_reg;
    end

    // Temperature divider chain with side data delay.
    logic        tv [NS+1];
    logic [31:0] tn [NS+1], td [NS+1], tq [NS+1], tr [NS+1];
    logic [31:0] tx1 [NS+1];
    logic        tz [NS+1], tneg [NS+1];
    logic [18:0] tup [NS+1];
    assign tv[0] = v2_reg; assign tn[0] = an2_reg; assign td[0] = ad2_reg;
    assign tq[0] = '0; assign tr[0] = '0;
    assign tx1[0] = x12_reg; assign tz[0] = z2_reg; assign tneg[0] = neg2_reg;
    assign tup[0] = up2_reg;
    for (genvar g = 0; g < NS; g++)
    begin : g_tdiv
        brc_div_stage #(.W(DivBits), .S(DS)) u_st (
            .clk(clk), .rst_n(rst_n), .v(tv[g]), .n_in(tn[g]), .d(td[g]),
            .q_in(tq[g]), .r_in(tr[g]), .v_reg(tv[g+1]), .n_reg(tn[g+1]),
            .d_reg(td[g+1]), .q_reg(tq[g+1]), .r_reg(tr[g+1])
        );
        always_ff @(posedge clk)
        begin
            tx1[g+1] <= tx1[g]; tz[g+1] <= tz[g]; tneg[g+1] <= tneg[g];
            tup[g+1] <= tup[g];
        end
    end

    // s3: b5, temperature, b6
    logic [31:0] b5_3, t3;
    logic        v3_reg, z3_reg;
    logic [31:0] b6_3_reg;
    logic [15:0] tt3_reg;
    logic [18:0] up3_reg;
    always_comb
    begin
        b5_3 = tx1[NS] + (tneg[NS] ? 32'(-tq[NS]) : tq[NS]);
        t3 = asr32(b5_3 + 32'd8, 5'd4);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v3_reg <= 1'b0;
        else        v3_reg <= tv[NS];
    end
    always_ff @(posedge clk)
    begin
        z3_reg   <= tz[NS];
        b6_3_reg <= b5_3 - 32'd4000;
        if ($signed(t3) > 32'sd32767)       tt3_reg <= 16'h7FFF;
        else if ($signed(t3) < -32'sd32768) tt3_reg <= 16'h8000;
        else                                tt3_reg <= t3[15:0];
        up3_reg  <= tup[NS];
    end

    // s4: b6 squared, ac2*b6, ac3*b6
    logic        v4_reg, z4_reg;
    logic [31:0] sqp4_reg, a2p4_reg, a3p4_reg;
    logic [15:0] tt4_reg;
    logic [18:0] up4_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v4_reg <= 1'b0;
        else        v4_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        z4_reg   <= z3_reg;
        sqp4_reg <= b6_3_reg * b6_3_reg;
        a2p4_reg <= cal.ac2 * b6_3_reg;
        a3p4_reg <= cal.ac3 * b6_3_reg;
        tt4_reg  <= tt3_reg;
        up4_reg  <= up3_reg;
    end

    // s5: b2*sq, b1*sq
    logic [31:0] sq5;
    logic        v5_reg, z5_reg;
    logic [31:0] b2p5_reg, b1p5_reg, a2p5_reg, a3p5_reg;
    logic [15:0] tt5_reg;
    logic [18:0] up5_reg;
    assign sq5 = asr32(sqp4_reg, 5'd12);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v5_reg <= 1'b0;
        else        v5_reg <= v4_reg;
    end
    always_ff @(posedge clk)
    begin
        z5_reg <= z4_reg;
        b2p5_reg <= cal.b2 * sq5;
        b1p5_reg <= cal.b1 * sq5;
        a2p5_reg <= a2p4_reg;
        a3p5_reg <= a3p4_reg;
        tt5_reg  <= tt4_reg;
        up5_reg  <= up4_reg;
    end

    // s6: b3 and x3 for b4
    logic [31:0] x3a6, b3_6, x3b6;
    logic        v6_reg, z6_reg;
    logic [31:0] b3_6_reg, x3_6_reg;
    logic [15:0] tt6_reg;
    logic [18:0] up6_reg;
    always_comb
    begin
        x3a6 = asr32(b2p5_reg, 5'd11) + asr32(a2p5_reg, 5'd11);
        b3_6 = asr32(((cal.ac1 * 32'd4 + x3a6) << cal.oss) + 32'd2, 5'd2);
        x3b6 = asr32(asr32(a3p5_reg, 5'd13) + asr32(b1p5_reg, 5'd16) + 32'd2, 5'd2);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v6_reg <= 1'b0;
        else        v6_reg <= v5_reg;
    end
    always_ff @(posedge clk)
    begin
        z6_reg <= z5_reg;
        b3_6_reg <= b3_6;
        x3_6_reg <= x3b6 + 32'd32768;
        tt6_reg  <= tt5_reg;
        up6_reg  <= up5_reg;
    end

    // s7: b4 and b7 products
    logic        v7_reg, z7_reg;
    logic [31:0] b4p7_reg, b7_7_reg;
    logic [15:0] tt7_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v7_reg <= 1'b0;
        else        v7_reg <= v6_reg;
    end
    always_ff @(posedge clk)
    begin
        z7_reg <= z6_reg;
        b4p7_reg <= cal.ac4 * x3_6_reg;
        b7_7_reg <= ({13'd0, up6_reg} - b3_6_reg) * (32'd50000 >> cal.oss);
        tt7_reg  <= tt6_reg;
    end

    // s8: divider operands
    logic [31:0] b4_8;
    logic        v8_reg, z8_reg, zb8_reg, big8_reg;
    logic [31:0] n8_reg, d8_reg;
    logic [15:0] tt8_reg;
    assign b4_8 = b4p7_reg >> 15;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v8_reg <= 1'b0;
        else        v8_reg <= v7_reg;
    end
    always_ff @(posedge clk)
    begin
        z8_reg  <= z7_reg;
        zb8_reg <= (b4_8 == 32'd0);
        big8_reg <= b7_7_reg[31];
        n8_reg  <= b7_7_reg[31] ? b7_7_reg : {b7_7_reg[30:0], 1'b0};
        d8_reg  <= b4_8;
        tt8_reg <= tt7_reg;
    end

    logic        pv [NS+1];
    logic [31:0] pn [NS+1], pd [NS+1], pq [NS+1], pr [NS+1];
    logic        pz [NS+1], pzb [NS+1], pbig [NS+1];
    logic [15:0] ptt [NS+1];
    assign pv[0] = v8_reg; assign pn[0] = n8_reg; assign pd[0] = d8_reg;
    assign pq[0] = '0; assign pr[0] = '0;
    assign pz[0] = z8_reg; assign pzb[0] = zb8_reg; assign pbig[0] = big8_reg;
    assign ptt[0] = tt8_reg;
    for (genvar g = 0; g < NS; g++)
    begin : g_pdiv
        brc_div_stage #(.W(DivBits), .S(DS)) u_st (
            .clk(clk), .rst_n(rst_n), .v(pv[g]), .n_in(pn[g]), .d(pd[g]),
            .q_in(pq[g]), .r_in(pr[g]), .v_reg(pv[g+1]), .n_reg(pn[g+1]),
            .d_reg(pd[g+1]), .q_reg(pq[g+1]), .r_reg(pr[g+1])
        );
        always_ff @(posedge clk)
        begin
            pz[g+1] <= pz[g]; pzb[g+1] <= pzb[g]; pbig[g+1] <= pbig[g];
            ptt[g+1] <= ptt[g];
        end
    end

    // s9: p and x1 square
    logic [31:0] p9, x9;
    logic        v9_reg, z9_reg, zb9_reg;
    logic [31:0] p9_reg, sq9_reg, m9_reg;
    logic [15:0] tt9_reg;
    always_comb
    begin
        p9 = pbig[NS] ? {pq[NS][30:0], 1'b0} : pq[NS];
        x9 = asr32(p9, 5'd8);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v9_reg <= 1'b0;
        else        v9_reg <= pv[NS];
    end
    always_ff @(posedge clk)
    begin
        z9_reg <= pz[NS]; zb9_reg <= pzb[NS];
        p9_reg <= p9;
        sq9_reg <= x9 * x9;
        m9_reg <= p9 * 32'(-32'sd7357);
        tt9_reg <= ptt[NS];
    end

    // s10: times 3038
    logic        v10_reg, z10_reg, zb10_reg;
    logic [31:0] p10_reg, k10_reg, m10_reg;
    logic [15:0] tt10_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v10_reg <= 1'b0;
        else        v10_reg <= v9_reg;
    end
    always_ff @(posedge clk)
    begin
        z10_reg <= z9_reg; zb10_reg <= zb9_reg;
        p10_reg <= p9_reg;
        k10_reg <= sq9_reg * 32'd3038;
        m10_reg <= m9_reg;
        tt10_reg <= tt9_reg;
    end

    // s11: final sum and result register
    logic [31:0] pf;
    assign pf = p10_reg + asr32(asr32(k10_reg, 5'd16) + asr32(m10_reg, 5'd16)
                                + 32'd3791, 5'd4);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done <= 1'b0;
        else        done <= v10_reg;
    end
    always_ff @(posedge clk)
    begin
        priority if (z10_reg)
        begin
            temperature_tenths <= '0; pressure_pa <= '0; status <= STATUS_TEMP_DIV;
        end
        else if (zb10_reg)
        begin
            temperature_tenths <= tt10_reg; pressure_pa <= '0; status <= STATUS_PRES_DIV;
        end
        else
        begin
            temperature_tenths <= tt10_reg; pressure_pa <= pf; status <= STATUS_OK;
        end
    end

    logic unused_lat;
    assign unused_lat = (LAT == 0);

    // The last divider stages' numerator, divisor and remainder are not needed.
    logic unused_tail;
    assign unused_tail = ^{tn[NS], td[NS], tr[NS], pn[NS], pd[NS], pr[NS]};
endmodule
`default_nettype wire

[bench/barometer_reading_compensation_core_tb.sv]
`timescale 1ns / 100ps
module barometer_reading_compensation_core_tb;
    import brc_pkg::*;

    typedef struct packed {
        logic signed [15:0] tenths;
        logic signed [31:0] pascal;
        logic [1:0]         code;
    } reading_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] raw_temperature;
    logic [18:0] raw_pressure;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;
    logic        done;
    logic signed [15:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic [1:0]  status;

    logic [47:0] cal_a;
    logic [47:0] cal_c;
    logic [31:0] cal_b;
    logic [31:0] cal_m;
    logic [1:0]  oss_setting;

    reading_t readings_due[$];
    int       mismatches;
    int       quiet_cycles;
    bit       no_idle;

    barometer_reading_compensation_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .temperature_tenths(temperature_tenths),
        .pressure_pa(pressure_pa), .status(status)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [31:0] ext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] shr(input logic [31:0] v, input int n);
        return $signed(v) >>> n;
    endfunction

    function automatic reading_t compensate(input logic [15:0] ut, input logic [18:0] up);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, den, b5, b6, b3, b4, b7, p, sq;
        longint      t;
        reading_t    r;
        ac1 = ext16(cal_a[47:32]);
        ac2 = ext16(cal_a[31:16]);
        ac3 = ext16(cal_a[15:0]);
        ac4 = {16'd0, cal_c[47:32]};
        ac5 = {16'd0, cal_c[31:16]};
        ac6 = {16'd0, cal_c[15:0]};
        b1 = ext16(cal_b[31:16]);
        b2 = ext16(cal_b[15:0]);
        mc = ext16(cal_m[31:16]);
        md = ext16(cal_m[15:0]);
        r = '0;
        x1 = shr(({16'd0, ut} - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0)
        begin
            r.code = STATUS_TEMP_DIV;
            return r;
        end
        x2 = 32'($signed(mc << 11) / $signed(den));
        b5 = x1 + x2;
        t = longint'($signed(shr(b5 + 32'd8, 4)));
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        r.tenths = 16'(t);
        b6 = b5 - 32'd4000;
        sq = shr(b6 * b6, 12);
        x1 = shr(b2 * sq, 11);
        x2 = shr(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = shr(((ac1 * 32'd4 + x3) << oss_setting) + 32'd2, 2);
        x1 = shr(ac3 * b6, 13);
        x2 = shr(b1 * sq, 16);
        x3 = shr(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        b7 = ({13'd0, up} - b3) * (32'd50000 >> oss_setting);
        if (b4 == 0)
        begin
            r.code = STATUS_PRES_DIV;
            return r;
        end
        if (b7 < 32'h8000_0000)
            p = (b7 * 32'd2) / b4;
        else
            p = (b7 / b4) * 32'd2;
        x1 = shr(p, 8);
        x1 = x1 * x1;
        x1 = shr(x1 * 32'd3038, 16);
        x2 = shr(p * (32'd0 - 32'd7357), 16);
        p = p + shr(x1 + x2 + 32'd3791, 4);
        r.pascal = p;
        r.code = STATUS_OK;
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_CAL_FIRST: cal_a = value;
            REG_CAL_SECOND: cal_c = value;
            REG_CAL_B: cal_b = value[31:0];
            REG_CAL_M: cal_m = value[31:0];
            default: oss_setting = value[1:0];
        endcase
        @(posedge clk);
    endtask

    task automatic settle;
        start <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic load_calibration(input logic [47:0] a, input logic [47:0] c,
                                    input logic [31:0] b, input logic [31:0] m,
                                    input logic [1:0] o);
        settle();
        write_reg(REG_CAL_FIRST, a);
        write_reg(REG_CAL_SECOND, c);
        write_reg(REG_CAL_B, {16'd0, b});
        write_reg(REG_CAL_M, {16'd0, m});
        write_reg(REG_OSS, {46'd0, o});
        cfg_we <= 1'b0;
    endtask

    task automatic send_reading(input logic [15:0] ut, input logic [18:0] up);
        while (!no_idle && $urandom_range(99) < 11)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        raw_temperature <= ut;
        raw_pressure <= up;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        readings_due.push_back(compensate(ut, up));
    endtask

    task automatic test_typical_calibration;
        load_calibration({16'sd408, -16'sd72, -16'sd14383}, {16'd32741, 16'd32757, 16'd23153},
                         {16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868}, 2'd0);
        send_reading(16'd27898, 19'd23843);
        send_reading(16'd0, 19'd0);
        send_reading(16'hFFFF, 19'h7FFFF);
        send_reading(16'd23153, 19'd40000);
        settle();
        write_reg(REG_OSS, 48'd3);
        cfg_we <= 1'b0;
        send_reading(16'd27898, 19'd190744);
        send_reading(16'hFFFF, 19'd0);
    endtask

    task automatic test_divisor_zero;
        load_calibration(48'd0, 48'd0, 32'd0, 32'd0, 2'd1);
        send_reading(16'd100, 19'd500);
        load_calibration(48'd0, {16'd0, 16'd32768, 16'd0}, 32'd0, {16'd100, 16'd5}, 2'd2);
        send_reading(16'd1, 19'd1000);
        send_reading(16'd0, 19'd1000);
    endtask

    task automatic test_extreme_calibration;
        load_calibration({48{1'b1}}, {48{1'b1}}, {32{1'b1}}, {32{1'b1}}, 2'd3);
        send_reading(16'hFFFF, 19'h7FFFF);
        send_reading(16'h0000, 19'h00000);
        load_calibration({3{16'h8000}}, {3{16'h7FFF}}, {2{16'h8000}}, {16'h7FFF, 16'h8000}, 2'd0);
        send_reading(16'h8000, 19'h40000);
        send_reading(16'h7FFF, 19'h3FFFF);
    endtask

    task automatic test_random_readings(input int count);
        for (int k = 0; k < count; k++)
        begin
            if (k % 100 == 0)
            begin
                if ($urandom_range(3) == 0)
                    load_calibration(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                     $urandom, $urandom, 2'($urandom));
                else
                    load_calibration({16'($urandom_range(9000) - 4500),
                                      16'($urandom_range(2000) - 1000),
                                      16'($urandom_range(32767) - 16384)},
                                     {16'($urandom_range(65535, 20000)),
                                      16'($urandom_range(40000, 20000)),
                                      16'($urandom_range(30000, 10000))},
                                     {16'($urandom_range(8000)), 16'($urandom_range(200))},
                                     {16'($urandom_range(12000) - 12000),
                                      16'($urandom_range(4000))},
                                     2'($urandom));
            end
            no_idle = (k >= 300 && k < 400);
            if ($urandom_range(9) == 0)
                send_reading(16'($urandom), 19'($urandom));
            else
                send_reading(16'($urandom_range(40000, 15000)),
                             19'($urandom_range(40000, 15000) << oss_setting));
        end
        no_idle = 1'b0;
    endtask

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && done)
        begin
            if (readings_due.size() == 0)
            begin
                $error("Result transfer with none expected");
                mismatches++;
            end
            else
            begin
                want = readings_due.pop_front();
                if (temperature_tenths !== want.tenths)
                begin
                    $error("temperature_tenths: expected %0d, got %0d",
                           want.tenths, temperature_tenths);
                    mismatches++;
                end
                if (pressure_pa !== want.pascal)
                begin
                    $error("pressure_pa: expected %0d, got %0d", want.pascal, pressure_pa);
                    mismatches++;
                end
                if (status !== want.code)
                begin
                    $error("status: expected %0d, got %0d", want.code, status);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0;
        quiet_cycles = 0;
        no_idle = 1'b0;
        cal_a = '0;
        cal_c = '0;
        cal_b = '0;
        cal_m = '0;
        oss_setting = '0;
        rst_n = 1'b0;
        start = 1'b0;
        raw_temperature = '0;
        raw_pressure = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_typical_calibration();
        test_divisor_zero();
        test_extreme_calibration();
        test_random_readings(800);
        settle();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

[sim.f]
hdl/brc_pkg.sv
hdl/brc_div_stage.sv
hdl/barometer_reading_compensation_core.sv
bench/barometer_reading_compensation_core_tb.sv
